/* hdl/hse_pkg.sv */
// Shared constants, controller states and command/status bundles of the heap sort engine.
package hse_pkg;

    localparam int HSE_CAPACITY = 64;
    localparam int VALUE_W      = 32;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_BUILD_RD,
        S_BUILD_LD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_EXT_RD,
        S_EXT_WR,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } hse_state_t;

    typedef struct packed {
        logic load_en;
        logic build_init;
        logic build_rd;
        logic build_ld;
        logic sift_rd;
        logic sift_cmp;
        logic ext_init;
        logic ext_rd;
        logic ext_wr;
        logic i_dec;
        logic emit_init;
        logic emit_rd;
        logic emit_ld;
        logic run_clear;
    } hse_cmd_t;

    typedef struct packed {
        logic last_fire;
        logic n_lt2;
        logic i_one;
        logic child_out;
        logic go_down;
        logic out_xfer;
        logic out_end;
    } hse_sts_t;

endpackage

/* hdl/hse_in_if.sv */
// Input channel: one element per transfer, with a last marker.
interface hse_in_if;
    import hse_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

/* hdl/hse_out_if.sv */
// Output channel: one sorted element per transfer, with run flags.
interface hse_out_if;
    import hse_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      end_of_run;
    logic                      dropped;

    modport source (output valid, output sorted_value, output end_of_run, output dropped,
                    input ready);
    modport sink   (input valid, input sorted_value, input end_of_run, input dropped,
                    output ready);
endinterface

/* hdl/hse_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd0_reg;
    logic [WIDTH-1:0] rd1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd0_reg <= mem_reg[raddr0];
        rd1_reg <= mem_reg[raddr1];
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;
endmodule

/* hdl/hse_ctrl.sv */
// Controller state machine: sequences load, heap build, extraction and drain.
module hse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  hse_pkg::hse_sts_t sts,
    output hse_pkg::hse_cmd_t cmd
);
    import hse_pkg::*;

    hse_state_t state_reg;
    hse_state_t state_next;
    logic       phase_reg;   // 0: heap build, 1: extraction
    logic       phase_next;
    logic       sift_done;

    assign sift_done = ((state_reg == S_SIFT_RD) && sts.child_out)
                    || ((state_reg == S_SIFT_CMP) && !sts.go_down);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (sts.last_fire)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                phase_next = 1'b0;
                state_next = sts.n_lt2 ? S_EMIT_RD : S_BUILD_RD;
            end
            S_BUILD_RD:  state_next = S_BUILD_LD;
            S_BUILD_LD:  state_next = S_SIFT_RD;
            S_SIFT_RD,
            S_SIFT_CMP:
            begin
                if (sift_done)
                begin
                    if (!phase_reg)
                    begin
                        if (sts.i_one)
                        begin
                            state_next = S_EXT_RD;
                            phase_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_BUILD_RD;
                        end
                    end
                    else
                    begin
                        state_next = sts.i_one ? S_EMIT_RD : S_EXT_RD;
                    end
                end
                else
                begin
                    state_next = (state_reg == S_SIFT_RD) ? S_SIFT_CMP : S_SIFT_RD;
                end
            end
            S_EXT_RD:    state_next = S_EXT_WR;
            S_EXT_WR:    state_next = S_SIFT_RD;
            S_EMIT_RD:   state_next = S_EMIT_LD;
            S_EMIT_LD:   state_next = S_EMIT_WAIT;
            S_EMIT_WAIT:
            begin
                if (sts.out_xfer)
                begin
                    state_next = sts.out_end ? S_LOAD : S_EMIT_RD;
                end
            end
            default:     state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.load_en    = (state_reg == S_LOAD);
        cmd.build_init = (state_reg == S_START) && !sts.n_lt2;
        cmd.build_rd   = (state_reg == S_BUILD_RD);
        cmd.build_ld   = (state_reg == S_BUILD_LD);
        cmd.sift_rd    = (state_reg == S_SIFT_RD);
        cmd.sift_cmp   = (state_reg == S_SIFT_CMP);
        cmd.ext_init   = sift_done && !phase_reg && sts.i_one;
        cmd.ext_rd     = (state_reg == S_EXT_RD);
        cmd.ext_wr     = (state_reg == S_EXT_WR);
        cmd.i_dec      = sift_done && !sts.i_one;
        cmd.emit_init  = ((state_reg == S_START) && sts.n_lt2)
                      || (sift_done && phase_reg && sts.i_one);
        cmd.emit_rd    = (state_reg == S_EMIT_RD);
        cmd.emit_ld    = (state_reg == S_EMIT_LD);
        cmd.run_clear  = (state_reg == S_EMIT_WAIT) && sts.out_xfer && sts.out_end;
    end
endmodule

/* hdl/hse_dp.sv */
// Datapath: element store, counters, sift-down compare and output register.
module hse_dp #(
    parameter int CAPACITY = hse_pkg::HSE_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hse_pkg::hse_cmd_t cmd,
    output hse_pkg::hse_sts_t sts,
    hse_in_if.sink            elements,
    hse_out_if.source         sorted
);
    import hse_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    logic [CW-1:0]             count_reg;
    logic                      ovf_reg;
    logic                      out_valid_reg;
    logic [CW-1:0]             i_reg;
    logic [CW-1:0]             size_reg;
    logic [AW-1:0]             node_reg;
    logic signed [VALUE_W-1:0] node_val_reg;
    logic                      right_ok_reg;
    logic [CW-1:0]             k_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_end_reg;
    logic                      out_drop_reg;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [VALUE_W-1:0]        ram_wdata;
    logic [AW-1:0]             ram_raddr0;
    logic [AW-1:0]             ram_raddr1;
    logic [VALUE_W-1:0]        ram_rdata0;
    logic [VALUE_W-1:0]        ram_rdata1;

    logic                      in_xfer;
    logic                      room;
    logic [CW-1:0]             i_m1;
    logic [CW-1:0]             k_p1;
    logic [XW-1:0]             child_x;
    logic [XW-1:0]             child_r_x;
    logic [XW-1:0]             size_x;
    logic                      child_out;
    logic                      pick_right;
    logic signed [VALUE_W-1:0] left_val;
    logic signed [VALUE_W-1:0] right_val;
    logic signed [VALUE_W-1:0] big_val;
    logic [AW-1:0]             big_idx;
    logic                      go_down;

    hse_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (ram_raddr0),
        .raddr1 (ram_raddr1),
        .rdata0 (ram_rdata0),
        .rdata1 (ram_rdata1)
    );

    assign elements.ready = cmd.load_en;
    assign in_xfer        = elements.valid && cmd.load_en;
    assign room           = (count_reg < CW'(CAPACITY));

    assign i_m1      = i_reg - 1'b1;
    assign k_p1      = k_reg + 1'b1;
    assign child_x   = {1'b0, node_reg, 1'b1};
    assign child_r_x = child_x + 1'b1;
    assign size_x    = {{(XW - CW){1'b0}}, size_reg};
    assign child_out = (child_x >= size_x);

    assign left_val   = $signed(ram_rdata0);
    assign right_val  = $signed(ram_rdata1);
    assign pick_right = right_ok_reg && (right_val > left_val);
    assign big_val    = pick_right ? right_val : left_val;
    assign big_idx    = child_x[AW-1:0] + AW'(pick_right);
    assign go_down    = (big_val > node_val_reg);

    // Store port steering
    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = node_reg;
        ram_wdata  = node_val_reg;
        ram_raddr0 = '0;
        ram_raddr1 = '0;
        if (cmd.load_en)
        begin
            ram_we    = in_xfer && room;
            ram_waddr = count_reg[AW-1:0];
            ram_wdata = elements.value;
        end
        else if (cmd.build_rd)
        begin
            ram_raddr0 = i_m1[AW-1:0];
        end
        else if (cmd.sift_rd)
        begin
            ram_raddr0 = child_x[AW-1:0];
            ram_raddr1 = child_r_x[AW-1:0];
            ram_we     = child_out;
        end
        else if (cmd.sift_cmp)
        begin
            ram_we    = 1'b1;
            ram_wdata = go_down ? big_val : node_val_reg;
        end
        else if (cmd.ext_rd)
        begin
            ram_raddr1 = i_reg[AW-1:0];
        end
        else if (cmd.ext_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = i_reg[AW-1:0];
            ram_wdata = ram_rdata0;
        end
        else if (cmd.emit_rd)
        begin
            ram_raddr0 = k_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.run_clear)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (in_xfer)
            begin
                if (room)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.emit_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (sorted.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.build_init)
        begin
            i_reg    <= count_reg >> 1;
            size_reg <= count_reg;
        end
        else if (cmd.ext_init)
        begin
            i_reg <= count_reg - 1'b1;
        end
        else if (cmd.i_dec)
        begin
            i_reg <= i_m1;
        end
        if (cmd.ext_wr)
        begin
            size_reg <= i_reg;
        end
        if (cmd.build_ld)
        begin
            node_reg     <= i_m1[AW-1:0];
            node_val_reg <= $signed(ram_rdata0);
        end
        else if (cmd.ext_wr)
        begin
            node_reg     <= '0;
            node_val_reg <= $signed(ram_rdata1);
        end
        else if (cmd.sift_cmp && go_down)
        begin
            node_reg <= big_idx;
        end
        if (cmd.sift_rd)
        begin
            right_ok_reg <= (child_r_x < size_x);
        end
        if (cmd.emit_init)
        begin
            k_reg <= '0;
        end
        else if (cmd.emit_ld)
        begin
            k_reg         <= k_p1;
            out_value_reg <= $signed(ram_rdata0);
            out_end_reg   <= (k_p1 == count_reg);
            out_drop_reg  <= ovf_reg;
        end
    end

    assign sorted.valid        = out_valid_reg;
    assign sorted.sorted_value = out_value_reg;
    assign sorted.end_of_run   = out_end_reg;
    assign sorted.dropped      = out_drop_reg;

    assign sts.last_fire = in_xfer && elements.last;
    assign sts.n_lt2     = (count_reg < CW'(2));
    assign sts.i_one     = (i_reg == CW'(1));
    assign sts.child_out = child_out;
    assign sts.go_down   = go_down;
    assign sts.out_xfer  = out_valid_reg && sorted.ready;
    assign sts.out_end   = out_end_reg;
endmodule

/* hdl/heap_sort_engine_core.sv */
// Loading takes elements until the last marker. The set is then built into a heap by
// sift-down passes (each level reads both children at once from the two-read-port
// store, then compares and writes), sorted by repeated root extraction and drained in
// order. Throughput: one set at a time. Reset clears the state machine, element count,
// overflow flag and output valid; the element store is not cleared and needs no
// clearing pass.
module heap_sort_engine_core #(
    parameter int CAPACITY = hse_pkg::HSE_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    hse_in_if.sink    elements,
    hse_out_if.source sorted
);
    import hse_pkg::*;

    // Commands from the controller, status back from the datapath
    hse_cmd_t cmd;
    hse_sts_t sts;

    // Controller: walks load -> build heap -> extract root -> drain.
    // Each sift-down step is a read of both children followed by a
    // compare/write step; the node value rides in a register (hole method),
    // so only the final position of the sifted value gets written back.
    hse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Datapath: element store, loop indices, signed compare and the output
    // register that holds each sorted transfer until the sink takes it.
    hse_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .elements (elements),
        .sorted   (sorted)
    );

    // Loading and draining never overlap.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(sorted.valid && elements.ready))
        else $error("input ready while a sorted transfer is pending");

    // A last element closes the set: no further input until the run drains.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (elements.valid && elements.ready && elements.last) |=> !elements.ready)
        else $error("input still accepted after the last element");

    // Draining the final element reopens the input.
    a_end_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (sorted.valid && sorted.ready && sorted.end_of_run) |=> elements.ready)
        else $error("input not reopened after end of run");
endmodule

/* bench/heap_sort_engine_core_tb.sv */
// Self-checking bench for the heap sort engine: element sets in, ascending runs out.
module heap_sort_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hse_pkg::*;

    // Watchdog: cycles with no transfer on either channel before giving up.
    // The worst quiet stretch is a full 64-element sort followed by the long
    // receiver hold-off, so this leaves a wide margin.
    localparam int QUIET_LIMIT   = 20000;
    localparam int LONG_HOLD     = 500;
    localparam int DRAIN_CYCLES  = 50;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } element_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      end_of_run;
        logic                      dropped;
    } run_entry_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hse_in_if  elements_if ();
    hse_out_if sorted_if ();

    heap_sort_engine_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .elements (elements_if),
        .sorted   (sorted_if)
    );

    always #5 clk = ~clk;

    // Stimulus and expectation stores.
    element_t   element_queue [$];
    run_entry_t expected_runs [$];

    // Predictor state: the set gathered so far and whether any of it spilled.
    logic signed [VALUE_W-1:0] held [HSE_CAPACITY];
    int                        held_count = 0;
    logic                      spill_seen = 1'b0;

    // Knobs that the phase sequencer turns.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // Bookkeeping.
    int   items_queued   = 0;
    int   items_taken    = 0;
    int   results_seen   = 0;
    int   runs_done      = 0;
    int   spilled_runs   = 0;
    int   errors         = 0;
    int   quiet_cycles   = 0;
    logic in_took        = 1'b0;

    // Fold one accepted element into the predictor; on the last element of a
    // set, sort what was kept and queue the whole ascending run.
    task automatic take_element(input logic signed [VALUE_W-1:0] v, input logic is_last);
        logic signed [VALUE_W-1:0] run_vals [$];
        run_entry_t                entry;
        int                        pos;
        if (held_count < HSE_CAPACITY)
        begin
            held[held_count] = v;
            held_count++;
        end
        else
        begin
            spill_seen = 1'b1;
        end
        if (is_last)
        begin
            // Stable insertion: equal keys keep their arrival order.
            for (int i = 0; i < held_count; i++)
            begin
                pos = run_vals.size();
                for (int j = 0; j < run_vals.size(); j++)
                begin
                    if (run_vals[j] > held[i])
                    begin
                        pos = j;
                        break;
                    end
                end
                run_vals.insert(pos, held[i]);
            end
            for (int k = 0; k < run_vals.size(); k++)
            begin
                entry.sorted_value = run_vals[k];
                entry.end_of_run   = (k == run_vals.size() - 1);
                entry.dropped      = spill_seen;
                expected_runs.push_back(entry);
            end
            runs_done++;
            if (spill_seen)
                spilled_runs++;
            held_count = 0;
            spill_seen = 1'b0;
        end
    endtask

    // Compare one sorted transfer against the oldest expectation.
    task automatic check_result(input run_entry_t got);
        run_entry_t want;
        results_seen++;
        if (expected_runs.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected output, expected none, got value=%0d end_of_run=%0b dropped=%0b",
                     $time, got.sorted_value, got.end_of_run, got.dropped);
            return;
        end
        want = expected_runs.pop_front();
        if (got.sorted_value !== want.sorted_value)
        begin
            errors++;
            $display("%0t: sorted_value mismatch, expected %0d, got %0d",
                     $time, want.sorted_value, got.sorted_value);
        end
        if (got.end_of_run !== want.end_of_run)
        begin
            errors++;
            $display("%0t: end_of_run mismatch, expected %0b, got %0b",
                     $time, want.end_of_run, got.end_of_run);
        end
        if (got.dropped !== want.dropped)
        begin
            errors++;
            $display("%0t: dropped mismatch, expected %0b, got %0b",
                     $time, want.dropped, got.dropped);
        end
    endtask

    task automatic push_element(input logic signed [VALUE_W-1:0] v, input logic is_last);
        element_t e;
        e.value = v;
        e.last  = is_last;
        element_queue.push_back(e);
        items_queued++;
    endtask

    // Queue one set of random content: full-range words, the signed extremes,
    // small values near zero, and repeats of earlier members to force ties.
    task automatic push_random_set(input int len);
        logic signed [VALUE_W-1:0] members [$];
        logic signed [VALUE_W-1:0] v;
        int                        pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                v = $urandom;
            end
            else if (pick < 55)
            begin
                case ($urandom_range(4))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7FFF_FFFF;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            else if (pick < 75 || members.size() == 0)
            begin
                v = $signed($urandom_range(20)) - 10;
            end
            else
            begin
                v = members[$urandom_range(members.size() - 1)];
            end
            members.push_back(v);
            push_element(v, i == len - 1);
        end
    endtask

    // Block until the engine has taken every queued element and returned
    // every predicted result.
    task automatic wait_quiescent();
        while (items_taken != items_queued)
            @(negedge clk);
        while (expected_runs.size() != 0)
            @(negedge clk);
    endtask

    // Monitor: sample both channels at the rising edge.
    always @(posedge clk)
    begin
        run_entry_t got;
        in_took <= rst_n && elements_if.valid && elements_if.ready;
        if (rst_n && elements_if.valid && elements_if.ready)
        begin
            take_element(elements_if.value, elements_if.last);
            items_taken++;
        end
        if (rst_n && sorted_if.valid && sorted_if.ready)
        begin
            got.sorted_value = sorted_if.sorted_value;
            got.end_of_run   = sorted_if.end_of_run;
            got.dropped      = sorted_if.dropped;
            check_result(got);
        end
    end

    // Driver: advance to the next element once the current one has been
    // transferred, or idle instead at the phase's idle rate.
    always @(negedge clk)
    begin
        element_t e;
        if (rst_n && (!elements_if.valid || in_took))
        begin
            if (element_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                e = element_queue.pop_front();
                elements_if.valid <= 1'b1;
                elements_if.value <= e.value;
                elements_if.last  <= e.last;
            end
            else
            begin
                elements_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request that
    // is counted out here, independent of the sender.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            sorted_if.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            sorted_if.ready <= 1'b0;
            hold_left       <= LONG_HOLD - 1;
            hold_served     <= hold_served + 1;
        end
        else
        begin
            sorted_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (elements_if.valid && elements_if.ready)
                   || (sorted_if.valid && sorted_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Phase sequencer.
    initial
    begin
        int phase_items;
        int send_cfg [4];
        int stall_cfg [4];
        // Phases: free-running, idle sender, stalling receiver, both lightly.
        send_cfg  = '{0, 64, 0, 6};
        stall_cfg = '{0, 0, 64, 6};

        // Drive every input to a known value from time zero.
        elements_if.valid = 1'b0;
        elements_if.value = '0;
        elements_if.last  = 1'b0;
        sorted_if.ready   = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed sets: single extremes, a two-element signed pair, ties and
        // all the corner words together, already sorted and reversed input.
        push_element(32'sh7FFF_FFFF, 1'b1);
        push_element(32'sh8000_0000, 1'b1);
        push_element(32'sh7FFF_FFFF, 1'b0);
        push_element(32'sh8000_0000, 1'b1);
        push_element(0, 1'b0);
        push_element(-1, 1'b0);
        push_element(1, 1'b0);
        push_element(32'sh8000_0000, 1'b0);
        push_element(32'sh7FFF_FFFF, 1'b0);
        push_element(-1, 1'b0);
        push_element(0, 1'b1);
        push_element(5, 1'b0);
        push_element(5, 1'b0);
        push_element(5, 1'b1);
        push_element(3, 1'b0);
        push_element(2, 1'b0);
        push_element(1, 1'b1);
        push_element(-3, 1'b0);
        push_element(-2, 1'b0);
        push_element(-1, 1'b0);
        push_element(0, 1'b1);
        wait_quiescent();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_cfg[p];
            stall_pct     = stall_cfg[p];
            // One large set in the first three phases: exactly full, full when
            // the last element arrives, and several elements spilled.
            case (p)
                0: push_random_set(HSE_CAPACITY);
                1: push_random_set(HSE_CAPACITY + 1);
                2: push_random_set(HSE_CAPACITY + 4);
                default: ;
            endcase
            phase_items = 0;
            while (phase_items < 24)
            begin
                int len;
                len = $urandom_range(10, 1);
                push_random_set(len);
                phase_items += len;
            end
            // In the last phase, hold the receiver off while sets keep coming
            // so the engine fills, stops taking input and waits on the output.
            if (p == 3)
                hold_requests++;
            // Pause the sender until everything predicted has come back.
            wait_quiescent();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_runs.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected outputs never arrived", $time, expected_runs.size());
        end

        $display("Sorted %0d sets from %0d elements (%0d with overflow); %0d outputs checked.",
                 runs_done, items_taken, spilled_runs, results_seen);
        $display("Sender and receiver idle rates varied over four phases plus a long hold-off.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
